### hw/rtl/bmro_pkg.sv
// ----------------------------------------------------------------------------
// bmro_pkg
// Types and constants shared by the windowed mean and rms block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmro_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TICK_W    = 64;
  localparam int BS_W      = 11;
  localparam int OV_W      = 7;
  localparam int STEP_W    = 32;
  localparam int VSUM_W    = 27;
  localparam int SQSUM_W   = 41;
  localparam int PROD_W    = 18;
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int CNT_W     = 6;

  // overlap saturation and reciprocal of 100 for products below 2^18
  localparam logic [OV_W-1:0] OV_MAX      = 7'd99;
  localparam logic [18:0]     DIV100_MUL   = 19'd335545;
  localparam int              DIV100_SHIFT = 25;

  // last iteration index of the shared divider and the square root
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd40;
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd15;

  // cycles for the hop pipeline to settle after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE,
    CFG_OVERLAP,
    CFG_START_OFFSET,
    CFG_TICK_STEP
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic signed [TICK_W-1:0]   sample_tick;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [SAMPLE_W-1:0]        rms_value;
    logic signed [TICK_W-1:0]   window_start;
    logic signed [TICK_W-1:0]   window_end;
  } out_item_t;

  typedef struct packed {
    logic signed [VSUM_W-1:0] vsum;
    logic [SQSUM_W-1:0]       sqsum;
    logic [TICK_W-1:0]        tick;
  } job_t;

  typedef struct packed {
    logic [BS_W-1:0]   blk;
    logic [STEP_W-1:0] step;
    logic [TICK_W-1:0] offset;
  } cfg_t;

  typedef enum logic [1:0] {
    F_ACC,
    F_DROP_RD,
    F_DROP_SUB
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_TA,
    B_TB,
    B_TC,
    B_TD,
    B_DIVM,
    B_DIVS,
    B_SQRT,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

### hw/rtl/block_mean_rms_overlap_unit.sv
// ----------------------------------------------------------------------------
// block_mean_rms_overlap_unit
// Windowed mean and rms over signed samples with overlapping windows.
// ----------------------------------------------------------------------------
// While the window fills, a sample is taken whenever in_stall is low. When a
// window completes, the front part drops the oldest hop samples, each with a
// ring read state and a subtract state, before it takes the next sample. The
// first window needs block_size samples and each later one hop samples. The
// finished window waits in a two-entry queue; the back part works through
// setup states, two 41-step serial divisions, a 16-step square root and an
// output state that waits while out_stall is high, and takes the next window
// from the queue only after its result has been taken. After reset or any
// register write the input stalls while the hop is recomputed, and every
// write empties the window.
`default_nettype none

module block_mean_rms_overlap_unit #(
  parameter int MAX_BLOCK = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bmro_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bmro_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);
  import bmro_pkg::*;

  logic [BS_W-1:0]   block_size_r;
  logic [OV_W-1:0]   overlap_r;
  logic [TICK_W-1:0] offset_r;
  logic [STEP_W-1:0] step_r;
  logic [1:0]        settle_r;
  logic [PROD_W-1:0] prod_r;
  logic [BS_W-1:0]   hop_r;

  logic [BS_W-1:0]   eff_b;
  logic [OV_W-1:0]   ov_sat;
  logic [PROD_W+18:0] recip;
  cfg_t              cfg;
  job_t              push_job, pop_job;
  logic              push, pop, fifo_full, fifo_empty;

  // block size clamped to 1..MAX_BLOCK, overlap to 99
  always_comb begin
    if (block_size_r == '0) begin
      eff_b = BS_W'(1);
    end else if (32'(block_size_r) > MAX_BLOCK) begin
      eff_b = BS_W'(MAX_BLOCK);
    end else begin
      eff_b = block_size_r;
    end
    ov_sat = (overlap_r > OV_MAX) ? OV_MAX : overlap_r;
  end

  assign cfg.blk    = eff_b;
  assign cfg.step   = step_r;
  assign cfg.offset = offset_r;
  assign recip      = prod_r * DIV100_MUL;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BS_W'(10);
      overlap_r    <= '0;
      offset_r     <= '0;
      step_r       <= STEP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_BLOCK_SIZE:   block_size_r <= cfg_wdata[BS_W-1:0];
        CFG_OVERLAP:      overlap_r    <= cfg_wdata[OV_W-1:0];
        CFG_START_OFFSET: offset_r     <= cfg_wdata;
        CFG_TICK_STEP:    step_r       <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // hop = b - floor(b*ov/100), two registered stages
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(eff_b * ov_sat);
    hop_r  <= eff_b - BS_W'(recip >> DIV100_SHIFT);
  end

  // hold input while the hop settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  bmro_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .hold         (settle_r != 2'd0),
    .window_clear (cfg_we),
    .cfg          (cfg),
    .hop          (hop_r),
    .push         (push),
    .push_job     (push_job),
    .fifo_full    (fifo_full)
  );

  bmro_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (push_job),
    .full    (fifo_full),
    .pop     (pop),
    .job_out (pop_job),
    .empty   (fifo_empty)
  );

  bmro_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (fifo_empty),
    .job_in    (pop_job),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/bmro_front.sv
// ----------------------------------------------------------------------------
// bmro_front
// Takes samples, detects gaps, keeps the ring and running sums, hands full
// windows to the queue and then drops the oldest hop samples.
// ----------------------------------------------------------------------------
`default_nettype none

module bmro_front #(
  parameter int MAX_BLOCK = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire bmro_pkg::in_item_t in_data,
  output logic                   in_stall,
  input  wire logic              hold,
  input  wire logic              window_clear,
  input  wire bmro_pkg::cfg_t    cfg,
  input  wire logic [10:0]       hop,
  output logic                   push,
  output bmro_pkg::job_t         push_job,
  input  wire logic              fifo_full
);
  import bmro_pkg::*;

  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int AW = ((IW > BS_W) ? IW : BS_W) + 1;

  front_state_e state_r, state_nxt;

  logic [IW-1:0]              head_r, head_nxt;
  logic [BS_W-1:0]            fill_r, fill_nxt;
  logic [BS_W-1:0]            drop_r, drop_nxt;
  logic signed [VSUM_W-1:0]   vsum_r, vsum_nxt;
  logic [SQSUM_W-1:0]         sqsum_r, sqsum_nxt;
  logic [TICK_W-1:0]          exp_r, exp_nxt;
  logic                       have_prev_r, have_prev_nxt;

  logic signed [SAMPLE_W-1:0] ring [MAX_BLOCK];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic                       accept, gap, wr_en;
  logic [IW-1:0]              base_head, wr_addr;
  logic [BS_W-1:0]            base_fill, new_fill;
  logic signed [VSUM_W-1:0]   base_vsum, new_vsum;
  logic [SQSUM_W-1:0]         base_sqsum, new_sqsum;
  logic [AW-1:0]              addr_sum, head_inc;
  logic signed [2*SAMPLE_W-1:0] in_sq, old_sq;

  assign in_stall = !(state_r == F_ACC && !hold && !fifo_full);
  assign accept   = in_valid && !in_stall;
  assign gap      = have_prev_r && (in_data.sample_tick != exp_r);

  // window base after a possible gap
  assign base_head  = gap ? '0 : head_r;
  assign base_fill  = gap ? '0 : fill_r;
  assign base_vsum  = gap ? '0 : vsum_r;
  assign base_sqsum = gap ? '0 : sqsum_r;

  // ring write address, wrapped at the ring depth
  always_comb begin
    addr_sum = AW'(base_head) + AW'(base_fill);
    if (addr_sum >= AW'(MAX_BLOCK)) begin
      addr_sum = addr_sum - AW'(MAX_BLOCK);
    end
    wr_addr = addr_sum[IW-1:0];
  end

  // head advance when dropping
  always_comb begin
    head_inc = AW'(head_r) + AW'(1);
    if (head_inc == AW'(MAX_BLOCK)) begin
      head_inc = '0;
    end
  end

  assign in_sq     = in_data.sample_value * in_data.sample_value;
  assign old_sq    = rd_data_r * rd_data_r;
  assign new_fill  = base_fill + BS_W'(1);
  assign new_vsum  = base_vsum + VSUM_W'(in_data.sample_value);
  assign new_sqsum = base_sqsum + SQSUM_W'($unsigned(in_sq));
  assign wr_en     = accept;

  assign push_job.vsum  = new_vsum;
  assign push_job.sqsum = new_sqsum;
  assign push_job.tick  = in_data.sample_tick;

  // next state and window bookkeeping
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    vsum_nxt      = vsum_r;
    sqsum_nxt     = sqsum_r;
    exp_nxt       = exp_r;
    have_prev_nxt = have_prev_r;
    push          = 1'b0;
    unique case (state_r)
      F_ACC: begin
        if (accept) begin
          head_nxt      = base_head;
          fill_nxt      = new_fill;
          vsum_nxt      = new_vsum;
          sqsum_nxt     = new_sqsum;
          exp_nxt       = in_data.sample_tick + TICK_W'(cfg.step);
          have_prev_nxt = 1'b1;
          if (new_fill >= cfg.blk) begin
            push      = 1'b1;
            drop_nxt  = hop;
            state_nxt = F_DROP_RD;
          end
        end
      end
      F_DROP_RD: begin
        state_nxt = F_DROP_SUB;
      end
      F_DROP_SUB: begin
        vsum_nxt  = vsum_r - VSUM_W'(rd_data_r);
        sqsum_nxt = sqsum_r - SQSUM_W'($unsigned(old_sq));
        head_nxt  = head_inc[IW-1:0];
        fill_nxt  = fill_r - BS_W'(1);
        drop_nxt  = drop_r - BS_W'(1);
        state_nxt = (drop_r == BS_W'(1)) ? F_ACC : F_DROP_RD;
      end
      default: state_nxt = F_ACC;
    endcase
    if (window_clear) begin
      state_nxt     = F_ACC;
      head_nxt      = '0;
      fill_nxt      = '0;
      vsum_nxt      = '0;
      sqsum_nxt     = '0;
      have_prev_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_ACC;
      head_r      <= '0;
      fill_r      <= '0;
      drop_r      <= '0;
      vsum_r      <= '0;
      sqsum_r     <= '0;
      exp_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      vsum_r      <= vsum_nxt;
      sqsum_r     <= sqsum_nxt;
      exp_r       <= exp_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= in_data.sample_value;
    end
    rd_data_r <= ring[head_r];
  end

endmodule

`default_nettype wire

### hw/rtl/bmro_fifo.sv
// ----------------------------------------------------------------------------
// bmro_fifo
// Two-entry queue of finished windows between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bmro_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bmro_pkg::job_t job_in,
  output logic                full,
  input  wire logic           pop,
  output bmro_pkg::job_t      job_out,
  output logic                empty
);
  import bmro_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign job_out = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bmro_back.sv
// ----------------------------------------------------------------------------
// bmro_back
// Turns a finished window into a result: tick arithmetic, mean and mean
// square through one shared bit-serial divider, then a bit-serial sqrt.
// ----------------------------------------------------------------------------
`default_nettype none

module bmro_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           empty,
  input  wire bmro_pkg::job_t job_in,
  output logic                pop,
  input  wire bmro_pkg::cfg_t cfg,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bmro_pkg::out_item_t out_data
);
  import bmro_pkg::*;

  back_state_e state_r, state_nxt;

  job_t                     job_r;
  logic [STEP_W+BS_W-1:0]   p_r;
  logic [TICK_W-1:0]        acc_r, ws_r, we_r;
  logic [SQSUM_W-1:0]       dvd_r;
  logic [BS_W:0]            rem_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [RAD_W-1:0]         rad_r;
  logic [ROOT_W+1:0]        srem_r;
  logic [ROOT_W-1:0]        root_r;

  logic [BS_W:0]            div_shift, div_rem;
  logic                     div_bit;
  logic [ROOT_W+1:0]        sq_shift, sq_trial, sq_rem;
  logic                     sq_bit;
  logic [VSUM_W-1:0]        vmag;
  logic [SQSUM_W-1:0]       mean_q;

  // one restoring division step
  always_comb begin
    div_shift = {rem_r[BS_W-1:0], dvd_r[SQSUM_W-1]};
    div_bit   = (div_shift >= {1'b0, cfg.blk});
    div_rem   = div_bit ? (div_shift - {1'b0, cfg.blk}) : div_shift;
  end

  // one square root step
  always_comb begin
    sq_shift = {srem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
    sq_trial = {root_r, 2'b01};
    sq_bit   = (sq_shift >= sq_trial);
    sq_rem   = sq_bit ? (sq_shift - sq_trial) : sq_shift;
  end

  assign vmag   = job_r.vsum[VSUM_W-1] ? VSUM_W'(-job_r.vsum) : VSUM_W'(job_r.vsum);
  assign mean_q = {dvd_r[SQSUM_W-2:0], div_bit};

  // next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = B_MUL;
        end
      end
      B_MUL:  state_nxt = B_TA;
      B_TA:   state_nxt = B_TB;
      B_TB:   state_nxt = B_TC;
      B_TC:   state_nxt = B_TD;
      B_TD:   state_nxt = B_DIVM;
      B_DIVM: state_nxt = (cnt_r == DIV_LAST) ? B_DIVS : B_DIVM;
      B_DIVS: state_nxt = (cnt_r == DIV_LAST) ? B_SQRT : B_DIVS;
      B_SQRT: state_nxt = (cnt_r == SQRT_LAST) ? B_OUT : B_SQRT;
      B_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_r + CNT_W'(1);
    unique case (state_r)
      B_IDLE: begin
        job_r <= job_in;
      end
      B_MUL: begin
        p_r <= cfg.step * cfg.blk;
      end
      B_TA: begin
        acc_r <= job_r.tick + TICK_W'(cfg.step);
      end
      B_TB: begin
        acc_r <= acc_r - TICK_W'(p_r);
      end
      B_TC: begin
        ws_r <= acc_r + cfg.offset;
      end
      B_TD: begin
        we_r  <= ws_r + TICK_W'(p_r) - TICK_W'(1);
        dvd_r <= SQSUM_W'(vmag);
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_DIVM: begin
        dvd_r <= mean_q;
        rem_r <= div_rem;
        if (cnt_r == DIV_LAST) begin
          mean_r <= job_r.vsum[VSUM_W-1] ? SAMPLE_W'(-mean_q) : SAMPLE_W'(mean_q);
          dvd_r  <= job_r.sqsum;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end
      B_DIVS: begin
        dvd_r <= mean_q;
        rem_r <= div_rem;
        if (cnt_r == DIV_LAST) begin
          rad_r  <= mean_q[RAD_W-1:0];
          srem_r <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
      end
      B_SQRT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r <= sq_rem;
        root_r <= {root_r[ROOT_W-2:0], sq_bit};
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_data.mean_value   = mean_r;
  assign out_data.rms_value    = root_r;
  assign out_data.window_start = ws_r;
  assign out_data.window_end   = we_r;

endmodule

`default_nettype wire

### bench/block_mean_rms_overlap_unit_test.sv
// ----------------------------------------------------------------------------
// block_mean_rms_overlap_unit_test
// Drives samples with ticks through the windowed mean and rms block under
// several register settings, predicts each window result and compares every
// result transfer field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_rms_overlap_unit_test;
  import bmro_pkg::*;

  localparam int MAXB        = 1024;
  localparam int DRAIN_WAIT  = 400;
  localparam longint LIMIT   = 64'd3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  block_mean_rms_overlap_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [10:0]  reg_blk;
  logic [6:0]   reg_ovl;
  logic [63:0]  reg_offset;
  logic [31:0]  reg_step;
  longint       win_vals [MAXB];
  longint       win_sum;
  longint       win_sq;
  int           win_fill;
  int           win_head;
  int           win_hop;
  logic [63:0]  next_tick;
  bit           seen_any;

  out_item_t    pending_windows[$];
  int           errors;
  longint       cycle_count;
  bit           hold_off;
  int           hold_cycles;
  bit           run_done;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_blk();
    int b;
    b = reg_blk;
    if (b == 0) b = 1;
    if (b > MAXB) b = MAXB;
    return b;
  endfunction

  function automatic void clear_window();
    win_sum = 0;
    win_sq = 0;
    win_fill = 0;
    win_head = 0;
  endfunction

  function automatic void recalc_hop();
    int b;
    int ov;
    b = eff_blk();
    ov = (reg_ovl > 7'd99) ? 99 : int'(reg_ovl);
    win_hop = b - (b * ov) / 100;
  endfunction

  function automatic longint isqrt(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) begin
      // coarse step then fine step
      if ((r + 1024) * (r + 1024) <= x) r = r + 1024;
      else r = r + 1;
    end
    return r;
  endfunction

  // predictor: take one sample, maybe push a window result
  function automatic void predict_window(in_item_t s);
    longint v;
    int b;
    longint mean;
    out_item_t r;
    logic [63:0] first;
    v = longint'(s.sample_value);
    b = eff_blk();
    if (seen_any && s.sample_tick != next_tick) clear_window();
    next_tick = s.sample_tick + {32'd0, reg_step};
    seen_any = 1'b1;
    win_vals[(win_head + win_fill) % MAXB] = v;
    win_fill++;
    win_sum += v;
    win_sq += v * v;
    if (win_fill < b) return;
    mean = win_sum / b;
    first = s.sample_tick - 64'(b - 1) * {32'd0, reg_step};
    r.mean_value = mean[15:0];
    r.rms_value = 16'(isqrt(win_sq / b));
    r.window_start = first + reg_offset;
    r.window_end = first + reg_offset + {32'd0, reg_step} * 64'(b) - 64'd1;
    pending_windows.push_back(r);
    for (int k = 0; k < win_hop && win_fill > 0; k++) begin
      win_sum -= win_vals[win_head];
      win_sq -= win_vals[win_head] * win_vals[win_head];
      win_head = (win_head + 1) % MAXB;
      win_fill--;
    end
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checking, on each result transfer the receiver does not stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_windows.pop_front();
        if (out_data.mean_value !== want.mean_value) begin
          $display("%0t mean exp %0d got %0d", $time, want.mean_value,
                   out_data.mean_value);
          errors++;
        end
        if (out_data.rms_value !== want.rms_value) begin
          $display("%0t rms exp %0d got %0d", $time, want.rms_value,
                   out_data.rms_value);
          errors++;
        end
        if (out_data.window_start !== want.window_start) begin
          $display("%0t start exp %0d got %0d", $time, want.window_start,
                   out_data.window_start);
          errors++;
        end
        if (out_data.window_end !== want.window_end) begin
          $display("%0t end exp %0d got %0d", $time, want.window_end,
                   out_data.window_end);
          errors++;
        end
      end
    end
  end

  // receiver: random stall lengths, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
      hold_cycles <= 3000;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if (out_valid && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(0, 14);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BLOCK_SIZE:   reg_blk = val[10:0];
      CFG_OVERLAP:      reg_ovl = val[6:0];
      CFG_START_OFFSET: reg_offset = val;
      CFG_TICK_STEP:    reg_step = val[31:0];
      default: ;
    endcase
    recalc_hop();
    clear_window();
    seen_any = 1'b0;
  endtask

  // one sample transfer, with a random idle gap first when gaps is set
  task automatic send_sample(logic signed [15:0] v, logic [63:0] t, bit gaps);
    int idle;
    idle = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0) : 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample_value <= v;
    in_data.sample_tick <= t;
    do @(posedge clk); while (in_stall);
    predict_window('{sample_value: v, sample_tick: t});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // directed: extremes of values, gaps, first-sample ticks
  task automatic test_directed();
    logic [63:0] t;
    t = 64'h7FFF_FFFF_FFFF_FFFE;
    write_reg(CFG_BLOCK_SIZE, 64'd2);
    for (int i = 0; i < 4; i++) begin
      send_sample(-16'sd32768, t, 1'b0);
      t = t + 1;
    end
    for (int i = 0; i < 4; i++) begin
      send_sample(16'sd32767, t, 1'b0);
      t = t + 1;
    end
    // gap then a fresh window
    send_sample(16'sd5, t + 7, 1'b0);
    send_sample(-16'sd3, t + 8, 1'b0);
    send_sample(16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_sample(16'h5555, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
    drain();
    // block size zero behaves as one, step zero needs a constant tick
    write_reg(CFG_BLOCK_SIZE, 64'd0);
    write_reg(CFG_TICK_STEP, 64'd0);
    write_reg(CFG_START_OFFSET, 64'h8000_0000_0000_0000);
    for (int i = 0; i < 3; i++) send_sample(-16'sd7, 64'h5555_5555_5555_5555, 1'b0);
    drain();
  endtask

  // random settings and sequences with occasional tick gaps
  task automatic test_random(int n_items, int blk_cap);
    logic [63:0] t;
    logic [63:0] stp;
    int bs;
    bs = $urandom_range(1, blk_cap);
    write_reg(CFG_BLOCK_SIZE, 64'(bs));
    write_reg(CFG_OVERLAP, 64'($urandom_range(0, 127)));
    write_reg(CFG_START_OFFSET, {$urandom, $urandom});
    stp = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF : 64'($urandom_range(1, 5));
    write_reg(CFG_TICK_STEP, stp);
    t = {$urandom, $urandom};
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 40) == 0) t = {$urandom, $urandom};
      send_sample(16'($urandom), t, 1'b1);
      t = t + stp;
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering samples
  task automatic test_backpressure();
    logic [63:0] t;
    write_reg(CFG_BLOCK_SIZE, 64'd1);
    write_reg(CFG_OVERLAP, 64'd0);
    write_reg(CFG_TICK_STEP, 64'd1);
    t = 64'd100;
    @(posedge clk);
    hold_off <= 1'b1;
    @(posedge clk);
    hold_off <= 1'b0;
    for (int i = 0; i < 20; i++) begin
      send_sample(16'($urandom), t, 1'b0);
      t = t + 1;
    end
    drain();
  endtask

  // large window with saturated overlap and extreme ticks
  task automatic test_extreme_sizes();
    logic [63:0] t;
    write_reg(CFG_BLOCK_SIZE, 64'd300);
    write_reg(CFG_OVERLAP, 64'd127);
    write_reg(CFG_TICK_STEP, 64'd3);
    write_reg(CFG_START_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
    t = 64'h8000_0000_0000_0000;
    for (int i = 0; i < 310; i++) begin
      send_sample((i % 2) ? 16'sd32767 : -16'sd32768, t, 1'b0);
      t = t + 3;
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    reg_blk = 11'd10;
    reg_ovl = 7'd0;
    reg_offset = '0;
    reg_step = 32'd1;
    next_tick = '0;
    seen_any = 1'b0;
    clear_window();
    recalc_hop();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_directed();
    test_backpressure();
    for (int p = 0; p < 6; p++) test_random(35, 12);
    test_random(60, 40);
    test_extreme_sizes();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
